// ----- design/rectangle_canvas_painter_assert.svh -----
// Assertion helpers for the rectangle canvas painter.
// Each expects clk and rst_n in scope; checks are off while reset is held.
`ifndef RECTANGLE_CANVAS_PAINTER_ASSERT_SVH
`define RECTANGLE_CANVAS_PAINTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rectangle_canvas_painter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rectangle_canvas_painter: next-cycle check failed");

`endif

// ----- design/rcp_pkg.sv -----
`default_nettype none
package rcp_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int IDX_W     = $clog2(MAX_SIDE);
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int FRAC_BITS = 8;
  localparam int FIELD_W   = 20;
  localparam int COORD_W   = FIELD_W + 2;
  localparam int CHAR_W    = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [SIDE_W-1:0]         side_t;
  typedef logic [CHAR_W-1:0]         char_t;
  typedef logic [FIELD_W-1:0]        field_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t ONE = coord_t'(1) <<< FRAC_BITS;

  // operations
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG     = 2'd2;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_DRAW   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_REPORT = 2'd3;

  localparam char_t CHAR_FILLED  = 8'h52;
  localparam char_t CHAR_OUTLINE = 8'h72;

  localparam side_t RESET_SIDE = side_t'(MAX_SIDE);
  localparam char_t RESET_BG   = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic       filled;
    char_t      color;
    idx_t       col;
    idx_t       row;
    coord_t     left;
    coord_t     right;
    coord_t     top;
    coord_t     bottom;
    coord_t     left_in;
    coord_t     right_in;
    coord_t     top_in;
    coord_t     bottom_in;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic scanning;
  } bk_stat_t;

  function automatic side_t clamp_side(side_t v);
    if (v == '0) return side_t'(1);
    if (v > side_t'(MAX_SIDE)) return side_t'(MAX_SIDE);
    return v;
  endfunction

  function automatic coord_t sext_field(field_t v);
    return coord_t'(signed'(v));
  endfunction

endpackage
`default_nettype wire

// ----- design/rcp_front.sv -----
`default_nettype none
module rcp_front (
  input  wire logic [1:0]     in_operation,
  input  wire rcp_pkg::char_t in_rect_type,
  input  wire rcp_pkg::field_t in_rect_left,
  input  wire rcp_pkg::field_t in_rect_top,
  input  wire rcp_pkg::field_t in_rect_width,
  input  wire rcp_pkg::field_t in_rect_height,
  input  wire rcp_pkg::char_t in_paint_char,
  input  wire rcp_pkg::idx_t  in_pixel_col,
  input  wire rcp_pkg::idx_t  in_pixel_row,
  input  wire rcp_pkg::side_t dim_w,
  input  wire rcp_pkg::side_t dim_h,
  input  wire rcp_pkg::char_t bg_char,
  output rcp_pkg::cmd_t       cmd
);

  rcp_pkg::coord_t l, t, r, b;
  logic size_bad, type_bad, read_out;

  assign l = rcp_pkg::sext_field(in_rect_left);
  assign t = rcp_pkg::sext_field(in_rect_top);
  assign r = l + rcp_pkg::sext_field(in_rect_width);
  assign b = t + rcp_pkg::sext_field(in_rect_height);

  assign size_bad = in_rect_width[rcp_pkg::FIELD_W-1] || (in_rect_width == '0)
                 || in_rect_height[rcp_pkg::FIELD_W-1] || (in_rect_height == '0);
  assign type_bad = (in_rect_type != rcp_pkg::CHAR_FILLED)
                 && (in_rect_type != rcp_pkg::CHAR_OUTLINE);
  assign read_out = ({1'b0, in_pixel_col} >= dim_w) || ({1'b0, in_pixel_row} >= dim_h);

  always_comb begin
    cmd           = '0;
    cmd.col       = in_pixel_col;
    cmd.row       = in_pixel_row;
    cmd.left      = l;
    cmd.right     = r;
    cmd.top       = t;
    cmd.bottom    = b;
    cmd.left_in   = l + rcp_pkg::ONE;
    cmd.right_in  = r - rcp_pkg::ONE;
    cmd.top_in    = t + rcp_pkg::ONE;
    cmd.bottom_in = b - rcp_pkg::ONE;
    cmd.filled    = (in_rect_type == rcp_pkg::CHAR_FILLED);
    cmd.color     = in_paint_char;
    cmd.status    = rcp_pkg::ST_OK;
    unique case (in_operation)
      rcp_pkg::OP_CLEAR: begin
        cmd.kind  = rcp_pkg::CMD_CLEAR;
        cmd.color = bg_char;
      end
      rcp_pkg::OP_DRAW: begin
        if (size_bad || type_bad) begin
          cmd.kind   = rcp_pkg::CMD_REPORT;
          cmd.status = rcp_pkg::ST_BAD;
        end else begin
          cmd.kind = rcp_pkg::CMD_DRAW;
        end
      end
      rcp_pkg::OP_READ: begin
        if (read_out) begin
          cmd.kind   = rcp_pkg::CMD_REPORT;
          cmd.status = rcp_pkg::ST_RANGE;
        end else begin
          cmd.kind = rcp_pkg::CMD_READ;
        end
      end
      default: begin
        // unknown operation: report ok with nothing done
        cmd.kind = rcp_pkg::CMD_REPORT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/rcp_cmd_queue.sv -----
`default_nettype none
module rcp_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire rcp_pkg::cmd_t wr_data,
  input  wire logic          rd_en,
  output rcp_pkg::cmd_t      rd_data,
  output logic               q_full,
  output logic               q_empty
);

  rcp_pkg::cmd_t entry_r [rcp_pkg::QUEUE_DEPTH];
  logic [rcp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [rcp_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == rcp_pkg::QCNT_W'(rcp_pkg::QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- design/rcp_back.sv -----
`default_nettype none
module rcp_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rcp_pkg::side_t dim_w,
  input  wire rcp_pkg::side_t dim_h,
  input  wire logic           q_empty,
  input  wire rcp_pkg::cmd_t  q_data,
  output logic                q_pop,
  input  wire logic           res_pop,
  output logic                res_empty,
  output logic [1:0]          res_status,
  output rcp_pkg::char_t      res_pixel,
  output rcp_pkg::bk_stat_t   stat
);

  localparam logic [1:0] BS_IDLE = 2'd0;
  localparam logic [1:0] BS_SCAN = 2'd1;
  localparam logic [1:0] BS_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  rcp_pkg::cmd_t cmd_r;
  rcp_pkg::idx_t col_r, col_nxt, row_r, row_nxt;
  rcp_pkg::char_t rdata_r;
  logic res_vld_r, res_vld_nxt;
  logic [1:0] res_status_r;
  rcp_pkg::char_t res_pix_r;
  rcp_pkg::char_t mem [rcp_pkg::MEM_DEPTH];

  rcp_pkg::coord_t x, y;
  logic col_out, row_out, col_edge, row_edge, paint;
  logic last_col, last_row, res_load, start_scan;

  assign x = rcp_pkg::coord_t'({col_r, {rcp_pkg::FRAC_BITS{1'b0}}});
  assign y = rcp_pkg::coord_t'({row_r, {rcp_pkg::FRAC_BITS{1'b0}}});

  assign col_out  = (x < cmd_r.left) || (cmd_r.right < x);
  assign row_out  = (y < cmd_r.top) || (cmd_r.bottom < y);
  assign col_edge = (x < cmd_r.left_in) || (cmd_r.right_in < x);
  assign row_edge = (y < cmd_r.top_in) || (cmd_r.bottom_in < y);

  // clear paints everything; draw paints the border, and the inside when filled
  assign paint = (state_r == BS_SCAN)
              && ((cmd_r.kind == rcp_pkg::CMD_CLEAR)
               || (!col_out && !row_out && (col_edge || row_edge || cmd_r.filled)));

  assign last_col = ({1'b0, col_r} == dim_w - 1'b1);
  assign last_row = ({1'b0, row_r} == dim_h - 1'b1);
  assign res_load = (state_r == BS_FIN) && (!res_vld_r || res_pop);
  assign start_scan = (q_data.kind == rcp_pkg::CMD_CLEAR)
                   || (q_data.kind == rcp_pkg::CMD_DRAW);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    q_pop     = 1'b0;
    unique case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = start_scan ? BS_SCAN : BS_FIN;
        end
      end
      BS_SCAN: begin
        if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            row_nxt   = '0;
            state_nxt = BS_FIN;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      BS_FIN: begin
        if (res_load) begin
          state_nxt = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (res_load) begin
      res_vld_nxt = 1'b1;
    end else if (res_pop) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BS_IDLE;
      col_r     <= '0;
      row_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
    if (res_load) begin
      res_status_r <= cmd_r.status;
      res_pix_r    <= (cmd_r.kind == rcp_pkg::CMD_READ) ? rdata_r : '0;
    end
  end

  // canvas store: one write port for the scan, one registered read port
  always_ff @(posedge clk) begin
    if (paint) begin
      mem[{row_r, col_r}] <= cmd_r.color;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_data.kind == rcp_pkg::CMD_READ)) begin
      rdata_r <= mem[{q_data.row, q_data.col}];
    end
  end

  assign res_empty     = !res_vld_r;
  assign res_status    = res_status_r;
  assign res_pixel     = res_pix_r;
  assign stat.busy     = (state_r != BS_IDLE);
  assign stat.scanning = (state_r == BS_SCAN);

endmodule
`default_nettype wire

// ----- design/rectangle_canvas_painter.sv -----
// The back end takes one command at a time from a 2-entry queue that decouples the sides.
// A read or rejected item goes straight to the result slot; a clear or draw first scans all
// width*height pixels (65536 at full size). A result is loaded once the result slot is free.
// Reset (rst_n, synchronous, active low) clears control and configuration only; canvas
// contents are undefined until the first clear, and no clearing pass is run.
`default_nettype none
`include "rectangle_canvas_painter_assert.svh"
module rectangle_canvas_painter (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [rcp_pkg::SIDE_W-1:0] cfg_data,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            in_operation,
  input  wire logic [7:0]            in_rect_type,
  input  wire logic signed [19:0]    in_rect_left,
  input  wire logic signed [19:0]    in_rect_top,
  input  wire logic signed [19:0]    in_rect_width,
  input  wire logic signed [19:0]    in_rect_height,
  input  wire logic [7:0]            in_paint_char,
  input  wire logic [7:0]            in_pixel_col,
  input  wire logic [7:0]            in_pixel_row,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [1:0]                 out_status,
  output logic [7:0]                 out_pixel_char
);

  rcp_pkg::side_t width_r, height_r, dim_w, dim_h;
  rcp_pkg::char_t bg_r;
  rcp_pkg::cmd_t  front_cmd, q_data;
  rcp_pkg::bk_stat_t bk_stat;
  logic q_full, q_empty, q_pop, in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rcp_pkg::RESET_SIDE;
      height_r <= rcp_pkg::RESET_SIDE;
      bg_r     <= rcp_pkg::RESET_BG;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rcp_pkg::REG_WIDTH:  width_r  <= cfg_data;
        rcp_pkg::REG_HEIGHT: height_r <= cfg_data;
        rcp_pkg::REG_BG:     bg_r     <= cfg_data[rcp_pkg::CHAR_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign dim_w   = rcp_pkg::clamp_side(width_r);
  assign dim_h   = rcp_pkg::clamp_side(height_r);
  assign full    = q_full;
  assign in_take = push && !q_full;

  rcp_front u_front (
    .in_operation   (in_operation),
    .in_rect_type   (in_rect_type),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_paint_char  (in_paint_char),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_row   (in_pixel_row),
    .dim_w          (dim_w),
    .dim_h          (dim_h),
    .bg_char        (bg_r),
    .cmd            (front_cmd)
  );

  rcp_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_take),
    .wr_data (front_cmd),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  rcp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dim_w      (dim_w),
    .dim_h      (dim_h),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .res_pop    (pop),
    .res_empty  (empty),
    .res_status (out_status),
    .res_pixel  (out_pixel_char),
    .stat       (bk_stat)
  );

  `RCP_ASSERT_NOW(a_err_no_pixel, !empty && out_status != rcp_pkg::ST_OK, out_pixel_char == '0)
  `RCP_ASSERT_NOW(a_scan_no_pop, bk_stat.scanning, !q_pop)
  `RCP_ASSERT_NEXT(a_pop_busy, q_pop, bk_stat.busy)

endmodule
`default_nettype wire
